// File: rtl/core/oal_pkg.sv
package oal_pkg;

  localparam int CMD_W        = 4;
  localparam int POS_W        = 5;
  localparam int WORD_W       = 32;
  localparam int STAT_W       = 3;
  localparam int DEF_CAPACITY = 16;
  localparam int MAX_RESULTS  = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 4'd0,
    CMD_LIST   = 4'd1,
    CMD_INSERT = 4'd2,
    CMD_DELETE = 4'd3,
    CMD_SEARCH = 4'd4,
    CMD_LENGTH = 4'd5,
    CMD_CLEAR  = 4'd6,
    CMD_GET    = 4'd7,
    CMD_UPDATE = 4'd8
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_EMPTY     = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_BAD_POS   = 3'd3,
    STAT_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

endpackage

// File: rtl/core/oal_ram.sv
module oal_ram
  import oal_pkg::*;
#(
  parameter int DEPTH  = DEF_CAPACITY,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/ordered_array_list_engine.sv
// Ordered list of up to CAPACITY signed words, driven by one command per
// transaction (start while busy is low). Results come out one per cycle on
// strobe and cannot be held off; last marks the final one of a command.
// Append, length, clear, update and any rejected command pass through
// decode and finish only, and their result strobes in the cycle in which
// busy drops. List, search, get, insert and delete walk the entries
// through the single read port of the entry memory, one entry per cycle;
// list walks the fill count up to MAX_RESULTS, search the fill count, get
// one entry, insert and delete the entries shifted. The final result
// strobes no later than the cycle in which busy drops. Unused command
// codes return to idle from decode and produce no result.
module ordered_array_list_engine
  import oal_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [CMD_W-1:0]         command,
  input  logic [POS_W-1:0]         position,
  input  logic signed [WORD_W-1:0] value,
  output logic                     strobe,
  output logic [STAT_W-1:0]        status,
  output logic [POS_W-1:0]         where,
  output logic signed [WORD_W-1:0] word,
  output logic [POS_W-1:0]         filled,
  output logic                     last
);

  localparam int ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int MATCH_W = $clog2(MAX_RESULTS + 1);

  state_t                     state, state_next;
  logic [CMD_W-1:0]           cmd_q;
  logic [POS_W-1:0]           pos_q;
  logic [WORD_W-1:0]          val_q;
  logic [CNT_W-1:0]           fill, fill_next;
  logic [ADDR_W-1:0]          idx, idx_next;
  logic [ADDR_W-1:0]          idx_end, idx_end_next;
  logic                       rd_valid, rd_valid_next;
  logic [ADDR_W-1:0]          rd_idx, rd_idx_next;
  status_t                    stat_q, stat_next;
  logic                       pend_valid, pend_valid_next;
  logic [ADDR_W-1:0]          pend_idx, pend_idx_next;
  logic [MATCH_W-1:0]         match_cnt, match_cnt_next;

  logic                       we;
  logic [ADDR_W-1:0]          waddr, raddr;
  logic [WORD_W-1:0]          wdata, rdata;

  logic                       emit;
  status_t                    e_status;
  logic [CMP_W-1:0]           e_where;
  logic [WORD_W-1:0]          e_word;
  logic                       e_last;

  logic                       out_strobe;
  status_t                    out_status;
  logic [POS_W-1:0]           out_where;
  logic [WORD_W-1:0]          out_word;
  logic [POS_W-1:0]           out_filled;
  logic                       out_last;

  oal_ram #(
    .DEPTH  (CAPACITY),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill       <= '0;
      rd_valid   <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      state      <= state_next;
      fill       <= fill_next;
      rd_valid   <= rd_valid_next;
      out_strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      cmd_q <= command;
      pos_q <= position;
      val_q <= value;
    end
    idx        <= idx_next;
    idx_end    <= idx_end_next;
    rd_idx     <= rd_idx_next;
    stat_q     <= stat_next;
    pend_valid <= pend_valid_next;
    pend_idx   <= pend_idx_next;
    match_cnt  <= match_cnt_next;
    if (emit) begin
      out_status <= e_status;
      out_where  <= e_where[POS_W-1:0];
      out_word   <= e_word;
      out_filled <= POS_W'(fill_next);
      out_last   <= e_last;
    end
  end

  always_comb begin
    logic [CMP_W-1:0] fill_w;
    logic [CMP_W-1:0] pos_w;
    logic [CMP_W-1:0] q_w;
    logic [CMP_W-1:0] lim_w;
    logic             is_empty;
    logic             is_full;
    logic             pos_bad;

    fill_w   = CMP_W'(fill);
    pos_w    = CMP_W'(pos_q);
    q_w      = pos_w - CMP_W'(1);
    lim_w    = (fill_w > CMP_W'(MAX_RESULTS)) ? CMP_W'(MAX_RESULTS) : fill_w;
    is_empty = (fill == '0);
    is_full  = (fill_w >= CMP_W'(CAPACITY));
    pos_bad  = (pos_w == '0) || (pos_w > fill_w);

    state_next      = state;
    fill_next       = fill;
    idx_next        = idx;
    idx_end_next    = idx_end;
    rd_valid_next   = 1'b0;
    rd_idx_next     = rd_idx;
    stat_next       = stat_q;
    pend_valid_next = pend_valid;
    pend_idx_next   = pend_idx;
    match_cnt_next  = match_cnt;
    raddr           = idx;
    we              = 1'b0;
    waddr           = rd_idx;
    wdata           = rdata;
    emit            = 1'b0;
    e_status        = STAT_OK;
    e_where         = '0;
    e_word          = '0;
    e_last          = 1'b0;

    // read pipe: data read in the previous cycle is handled here
    if (rd_valid) begin
      case (cmd_q)
        CMD_LIST: begin
          emit    = 1'b1;
          e_where = CMP_W'(rd_idx) + CMP_W'(1);
          e_word  = rdata;
          e_last  = (rd_idx == idx_end);
        end
        CMD_GET: begin
          emit    = 1'b1;
          e_where = pos_w;
          e_word  = rdata;
          e_last  = 1'b1;
        end
        CMD_SEARCH: begin
          // a match is held back until the next one shows who is last
          if (rdata == val_q && match_cnt != MATCH_W'(MAX_RESULTS)) begin
            if (pend_valid) begin
              emit    = 1'b1;
              e_where = CMP_W'(pend_idx) + CMP_W'(1);
            end
            pend_valid_next = 1'b1;
            pend_idx_next   = rd_idx;
            match_cnt_next  = match_cnt + MATCH_W'(1);
          end
        end
        CMD_INSERT: begin
          we    = 1'b1;
          waddr = rd_idx + ADDR_W'(1);
        end
        CMD_DELETE: begin
          we    = 1'b1;
          waddr = rd_idx - ADDR_W'(1);
        end
        default: begin
        end
      endcase
    end

    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        stat_next       = STAT_OK;
        pend_valid_next = 1'b0;
        match_cnt_next  = '0;
        state_next      = S_FINISH;
        case (cmd_q)
          CMD_APPEND: begin
            if (is_full) stat_next = STAT_FULL;
          end
          CMD_LIST: begin
            if (is_empty) begin
              stat_next = STAT_EMPTY;
            end else begin
              idx_next     = '0;
              idx_end_next = ADDR_W'(lim_w - CMP_W'(1));
              state_next   = S_SCAN;
            end
          end
          CMD_SEARCH: begin
            if (is_empty) begin
              stat_next = STAT_EMPTY;
            end else begin
              idx_next     = '0;
              idx_end_next = ADDR_W'(fill_w - CMP_W'(1));
              state_next   = S_SCAN;
            end
          end
          CMD_INSERT: begin
            if (is_full) begin
              stat_next = STAT_FULL;
            end else if (pos_w == '0 || pos_w > fill_w + CMP_W'(1)) begin
              stat_next = STAT_BAD_POS;
            end else if (pos_w != fill_w + CMP_W'(1)) begin
              // shift from the top entry down to the insert point
              idx_next     = ADDR_W'(fill_w - CMP_W'(1));
              idx_end_next = ADDR_W'(q_w);
              state_next   = S_SCAN;
            end
          end
          CMD_DELETE: begin
            if (is_empty) begin
              stat_next = STAT_EMPTY;
            end else if (pos_bad) begin
              stat_next = STAT_BAD_POS;
            end else if (pos_w != fill_w) begin
              idx_next     = ADDR_W'(pos_w);
              idx_end_next = ADDR_W'(fill_w - CMP_W'(1));
              state_next   = S_SCAN;
            end
          end
          CMD_GET: begin
            if (is_empty) begin
              stat_next = STAT_EMPTY;
            end else if (pos_bad) begin
              stat_next = STAT_BAD_POS;
            end else begin
              idx_next     = ADDR_W'(q_w);
              idx_end_next = ADDR_W'(q_w);
              state_next   = S_SCAN;
            end
          end
          CMD_UPDATE: begin
            if (is_empty) begin
              stat_next = STAT_EMPTY;
            end else if (pos_bad) begin
              stat_next = STAT_BAD_POS;
            end
          end
          CMD_LENGTH, CMD_CLEAR: begin
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        raddr         = idx;
        rd_valid_next = 1'b1;
        rd_idx_next   = idx;
        if (idx == idx_end) begin
          state_next = S_DRAIN;
        end else if (cmd_q == CMD_INSERT) begin
          idx_next = idx - ADDR_W'(1);
        end else begin
          idx_next = idx + ADDR_W'(1);
        end
      end
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        state_next = S_IDLE;
        if (stat_q != STAT_OK) begin
          emit     = 1'b1;
          e_status = stat_q;
          e_last   = 1'b1;
        end else begin
          case (cmd_q)
            CMD_APPEND: begin
              we        = 1'b1;
              waddr     = ADDR_W'(fill);
              wdata     = val_q;
              fill_next = fill + CNT_W'(1);
              emit      = 1'b1;
              e_where   = fill_w + CMP_W'(1);
              e_last    = 1'b1;
            end
            CMD_INSERT: begin
              we        = 1'b1;
              waddr     = ADDR_W'(q_w);
              wdata     = val_q;
              fill_next = fill + CNT_W'(1);
              emit      = 1'b1;
              e_where   = pos_w;
              e_last    = 1'b1;
            end
            CMD_DELETE: begin
              fill_next = fill - CNT_W'(1);
              emit      = 1'b1;
              e_where   = pos_w;
              e_last    = 1'b1;
            end
            CMD_UPDATE: begin
              we      = 1'b1;
              waddr   = ADDR_W'(q_w);
              wdata   = val_q;
              emit    = 1'b1;
              e_where = pos_w;
              e_last  = 1'b1;
            end
            CMD_SEARCH: begin
              emit   = 1'b1;
              e_last = 1'b1;
              if (pend_valid) begin
                e_where = CMP_W'(pend_idx) + CMP_W'(1);
              end else begin
                e_status = STAT_NOT_FOUND;
              end
            end
            CMD_LENGTH: begin
              emit   = 1'b1;
              e_last = 1'b1;
            end
            CMD_CLEAR: begin
              fill_next = '0;
              emit      = 1'b1;
              e_last    = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy   = (state != S_IDLE);
  assign strobe = out_strobe;
  assign status = out_status;
  assign where  = out_where;
  assign word   = out_word;
  assign filled = out_filled;
  assign last   = out_last;

endmodule
